// ----- sv/lrukv_pkg.sv -----
package lrukv_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic                     opcode;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
	} rsp_t;

endpackage

// ----- sv/lrukv_table.sv -----
module lrukv_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  lrukv_pkg::req_t               req,
	input  logic [lrukv_pkg::CAP_W-1:0]   cap,
	output lrukv_pkg::rsp_t               rsp
);
	import lrukv_pkg::*;

	localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int AW   = IW;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic [MAX_ENTRIES-1:0]  entry_valid_q;
	logic [DATA_W-1:0]       entry_key_q  [MAX_ENTRIES];
	logic [DATA_W-1:0]       entry_data_q [MAX_ENTRIES];
	logic [AW-1:0]           entry_age_q  [MAX_ENTRIES];
	logic [CW-1:0]           live_count_q;

	logic [MAX_ENTRIES-1:0]  hit_vec;
	logic [MAX_ENTRIES-1:0]  lru_vec;
	logic [IW-1:0]           hit_idx;
	logic [IW-1:0]           lru_idx;
	logic [IW-1:0]           sel_idx;
	logic                    hit_any;
	logic [CMPW-1:0]         cap_ext;
	logic [CMPW-1:0]         eff_cap;
	logic                    is_put;
	logic                    do_evict;
	logic                    do_insert;
	logic                    do_touch;
	logic                    age_all;
	logic [AW-1:0]           ref_age;
	logic [AW-1:0]           lru_age;

	assign is_put  = (req.opcode == OP_PUT);
	assign lru_age = AW'(live_count_q - CW'(1));

	always_comb begin
		cap_ext = CMPW'(cap);
		if (cap_ext == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
			eff_cap = CMPW'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i] = entry_valid_q[i] && (entry_key_q[i] == req.key);
			lru_vec[i] = entry_valid_q[i] && (entry_age_q[i] == lru_age);
		end
	end

	// lowest index wins; keys are unique and ranks distinct anyway
	always_comb begin
		hit_idx = '0;
		lru_idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = IW'(i);
			if (lru_vec[i]) lru_idx = IW'(i);
		end
	end

	assign hit_any   = |hit_vec;
	assign do_evict  = is_put && !hit_any && (CMPW'(live_count_q) >= eff_cap);
	assign do_insert = is_put && !hit_any && !do_evict;
	assign do_touch  = is_put || hit_any;
	assign age_all   = do_insert;

	always_comb begin
		priority if (hit_any) begin
			sel_idx = hit_idx;
			ref_age = entry_age_q[hit_idx];
		end else if (do_evict) begin
			sel_idx = lru_idx;
			ref_age = lru_age;
		end else begin
			// valid entries always form a prefix, so the first free slot is the count
			sel_idx = live_count_q[IW-1:0];
			ref_age = '0;
		end
	end

	always_comb begin
		rsp.hit     = hit_any;
		rsp.evicted = do_evict;
		if (is_put) begin
			rsp.read_value = req.value;
		end else if (hit_any) begin
			rsp.read_value = entry_data_q[hit_idx];
		end else begin
			rsp.read_value = -32'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			live_count_q  <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				entry_age_q[i] <= '0;
			end
		end else if (fire && do_touch) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IW'(i) == sel_idx) begin
					entry_age_q[i] <= '0;
				end else if (entry_valid_q[i] && (age_all || entry_age_q[i] < ref_age)) begin
					entry_age_q[i] <= entry_age_q[i] + AW'(1);
				end
			end
			if (is_put) begin
				entry_valid_q[sel_idx] <= 1'b1;
			end
			if (do_insert) begin
				live_count_q <= live_count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_put) begin
			entry_key_q[sel_idx]  <= req.key;
			entry_data_q[sel_idx] <= req.value;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_valid_q) == int'(live_count_q))
		else $error("live count differs from valid entries");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		live_count_q <= CW'(MAX_ENTRIES))
		else $error("live count above table size");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_insert |=> live_count_q == $past(live_count_q) + CW'(1))
		else $error("insert did not grow live count");

	a_evict_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_evict |=> $stable(live_count_q))
		else $error("eviction changed live count");

	a_evict_only_miss_put: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.evicted |-> (is_put && !rsp.hit && live_count_q != '0))
		else $error("eviction on hit, get or empty table");
`endif

endmodule

// ----- sv/lru_key_value_cache_unit.sv -----
// LRU key-value cache, fully associative, MAX_ENTRIES entries.
// Command channel (cmd_valid/cmd_stall): opcode (get/put), key, value.
// Result channel (res_valid/res_stall): hit, read_value, evicted; one
// result per command, in order.
// A transferred command is held in the input register; the lookup, age update
// and result are computed combinationally from it and loaded into the result
// register when it advances, which waits while a held result is stalled.
// Throughput is one command per cycle while res_stall is low: the single compare/update pass over
// all entries sets it, and each command sees the table left by the one before.
// While the receiver stalls, the result register holds; a new command waits in
// the input register and cmd_stall rises once both are occupied.
// capacity_in_use (APB, address 0) sets how many entries are held before the
// least recent is evicted; 0 acts as 1, values above MAX_ENTRIES as MAX_ENTRIES.
// Write it only while no command is in flight.
// Reset empties the table, sets capacity to 16 and drops any pending
// command or result.
module lru_key_value_cache_unit #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic                                opcode,
	input  logic signed [lrukv_pkg::DATA_W-1:0] key,
	input  logic signed [lrukv_pkg::DATA_W-1:0] value,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                hit,
	output logic signed [lrukv_pkg::DATA_W-1:0] read_value,
	output logic                                evicted,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import lrukv_pkg::*;

	logic             valid_s1;
	req_t             req_s1;
	logic             res_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;
	logic             advance;
	logic [CAP_W-1:0] cap_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_CAPACITY) begin
			prdata = 32'(cap_q);
		end else begin
			prdata = '0;
		end
	end

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			req_s1.opcode <= opcode;
			req_s1.key    <= key;
			req_s1.value  <= value;
		end
	end

	lrukv_table #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.cap    (cap_q),
		.rsp    (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign res_valid  = res_valid_q;
	assign hit        = rsp_q.hit;
	assign read_value = rsp_q.read_value;
	assign evicted    = rsp_q.evicted;

endmodule

// ----- tb/testbench.sv -----
module testbench;
	import lrukv_pkg::*;

	localparam int ENTRIES     = 16;
	localparam int POOL_SIZE   = 24;
	localparam int IDLE_LIMIT  = 1000;
	localparam int BURST_AT    = 300;
	localparam int BURST_LEN   = 100;
	localparam logic REG_UNUSED = 1'b1;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_stall;
	logic                     opcode    = OP_GET;
	logic signed [DATA_W-1:0] key       = '0;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;
	logic                     evicted;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [2:0]               paddr     = '0;
	logic [31:0]              pwdata    = '0;
	logic [31:0]              prdata;
	logic                     pready;

	lru_key_value_cache_unit uut (
		.clk, .arst_n,
		.cmd_valid, .cmd_stall, .opcode, .key, .value,
		.res_valid, .res_stall, .hit, .read_value, .evicted,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cache shadow
	bit                       tbl_valid [ENTRIES];
	logic signed [DATA_W-1:0] tbl_key   [ENTRIES];
	logic signed [DATA_W-1:0] tbl_data  [ENTRIES];
	int unsigned              tbl_age   [ENTRIES];
	int unsigned              tbl_live = 0;
	logic [CAP_W-1:0]         tbl_cap  = CAP_RESET;

	req_t pending_cmds [$];
	rsp_t expected_rsp [$];
	logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

	int n_queued    = 0;
	int n_checked   = 0;
	int errors      = 0;
	int cmd_gap_max = 0;
	int res_gap_max = 0;
	int cmd_wait    = 0;
	int res_wait    = 0;
	int hold_left   = 0;
	int idle_cycles = 0;

	function automatic void refresh_entry(int s);
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[i] && i != s && tbl_age[i] < tbl_age[s])
				tbl_age[i]++;
		end
		tbl_age[s] = 0;
	endfunction

	function automatic rsp_t cache_predict(req_t rq);
		bit          found;
		bit          any;
		int          slot;
		int          eff;
		int unsigned best;
		rsp_t        r;
		found = 0;
		any   = 0;
		slot  = 0;
		best  = 0;
		eff   = (tbl_cap < 1) ? 1 : ((tbl_cap > ENTRIES) ? ENTRIES : int'(tbl_cap));
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (tbl_valid[i] && tbl_key[i] == rq.key) begin
				found = 1;
				slot  = i;
			end
		end
		r.hit        = 1'b0;
		r.read_value = -1;
		r.evicted    = 1'b0;
		if (rq.opcode == OP_GET) begin
			if (found) begin
				r.hit        = 1'b1;
				r.read_value = tbl_data[slot];
				refresh_entry(slot);
			end
		end else begin
			r.read_value = rq.value;
			if (found) begin
				r.hit          = 1'b1;
				tbl_data[slot] = rq.value;
				refresh_entry(slot);
			end else if (tbl_live + 1 > eff || tbl_live >= ENTRIES) begin
				// reuse the least recent slot
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i] && (!any || tbl_age[i] > best)) begin
						any  = 1;
						best = tbl_age[i];
						slot = i;
					end
				end
				if (any) begin
					r.evicted = 1'b1;
					refresh_entry(slot);
				end else begin
					slot         = 0;
					tbl_valid[0] = 1;
					tbl_age[0]   = 0;
					tbl_live     = 1;
				end
				tbl_key[slot]  = rq.key;
				tbl_data[slot] = rq.value;
			end else begin
				for (int i = ENTRIES - 1; i >= 0; i--) begin
					if (!tbl_valid[i])
						slot = i;
				end
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i])
						tbl_age[i]++;
				end
				tbl_valid[slot] = 1;
				tbl_key[slot]   = rq.key;
				tbl_data[slot]  = rq.value;
				tbl_age[slot]   = 0;
				tbl_live++;
			end
		end
		return r;
	endfunction

	// command driver
	always @(posedge clk) begin
		req_t sent;
		req_t nxt;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				sent.opcode = opcode;
				sent.key    = key;
				sent.value  = value;
				expected_rsp.push_back(cache_predict(sent));
			end
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_wait > 0) begin
					cmd_wait--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					nxt = pending_cmds.pop_front();
					opcode    <= nxt.opcode;
					key       <= nxt.key;
					value     <= nxt.value;
					cmd_valid <= 1'b1;
					cmd_wait = $urandom_range(0, cmd_gap_max);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						errors++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value, read_value);
						errors++;
					end
					if (evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, evicted);
						errors++;
					end
					n_checked++;
					if (n_checked == BURST_AT)
						hold_left = BURST_LEN;
				end
				res_wait = $urandom_range(0, res_gap_max);
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (res_wait > 0) begin
				res_wait--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_CAPACITY)
			tbl_cap = data[CAP_W-1:0];
		@(negedge clk);
	endtask

	task automatic send_cmd(input logic op, input logic [31:0] k, input logic [31:0] v);
		req_t rq;
		rq.opcode = op;
		rq.key    = k;
		rq.value  = v;
		pending_cmds.push_back(rq);
		n_queued++;
	endtask

	task automatic drain();
		wait (n_checked == n_queued);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_phase(input logic [CAP_W-1:0] cap, input int n, input int cgap,
			input int rgap);
		logic [31:0] data;
		logic [31:0] k;
		logic [31:0] v;
		int          span;
		data      = $urandom;
		data[CAP_W-1:0] = cap;
		reg_write(REG_CAPACITY, data);
		cmd_gap_max = cgap;
		res_gap_max = rgap;
		// keys mostly from a pool a little larger than the capacity
		span = (cap == 0) ? 5 : ((cap > ENTRIES) ? ENTRIES + 4 : cap + 4);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, span - 1)];
			case ($urandom_range(0, 11))
				0:       v = 32'h8000_0000;
				1:       v = 32'h7FFF_FFFF;
				2:       v = 32'h0;
				3:       v = 32'hFFFF_FFFF;
				default: v = $urandom;
			endcase
			send_cmd($urandom_range(0, 1) ? OP_PUT : OP_GET, k, v);
		end
		drain();
	endtask

	initial begin
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_cmd(OP_GET, 32'h8000_0000, 32'h0);
		send_cmd(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_cmd(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_cmd(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_cmd(OP_PUT, 32'h0, 32'h0);
		send_cmd(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_cmd(OP_GET, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
		send_cmd(OP_GET, 32'h1, 32'h0);
		drain();

		// capacity below the live count: each new key evicts one
		reg_write(REG_CAPACITY, 32'd2);
		send_cmd(OP_PUT, 32'd5, 32'd55);
		send_cmd(OP_GET, 32'h0, 32'h0);
		send_cmd(OP_PUT, 32'd6, 32'd66);
		send_cmd(OP_GET, 32'h7FFF_FFFF, 32'h0);
		drain();

		// unmapped register, must be ignored
		reg_write(REG_UNUSED, 32'd1);
		send_cmd(OP_PUT, 32'd7, 32'd77);
		drain();

		reg_write(REG_CAPACITY, 32'd0);
		send_cmd(OP_PUT, 32'd8, 32'd88);
		send_cmd(OP_GET, 32'd8, 32'h0);
		send_cmd(OP_PUT, 32'd8, 32'h8000_0000);
		drain();

		reg_write(REG_CAPACITY, 32'd31);
		send_cmd(OP_PUT, 32'd9, 32'd99);
		send_cmd(OP_GET, 32'd9, 32'h0);
		drain();

		random_phase(5'd16, 400, 5, 5);
		random_phase(5'd1, 120, 0, 0);
		random_phase(5'd0, 120, 5, 0);
		random_phase(5'd31, 150, 0, 5);
		random_phase(5'd17, 150, 5, 5);
		random_phase(5'd3, 150, 0, 0);
		random_phase(5'd8, 150, 5, 5);
		for (int p = 0; p < 3; p++)
			random_phase(CAP_W'($urandom_range(0, 31)), 150, $urandom_range(0, 1) * 5,
				$urandom_range(0, 1) * 5);
		random_phase(5'd16, 150, 0, 0);

		if (errors == 0 && expected_rsp.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- lru_key_value_cache_unit.f -----
sv/lrukv_pkg.sv
sv/lrukv_table.sv
sv/lru_key_value_cache_unit.sv
tb/testbench.sv
